>>> sv/sms_pkg.sv
// Shared constants and types for the sorted membership set.
// No dependencies; imported by sms_cell and sorted_membership_set.
package sms_pkg;

  // Set capacity and derived widths
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int FUNC_W   = 2;
  localparam int MCNT_W   = 5;

  // Request codes
  localparam logic [FUNC_W-1:0] OP_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] OP_DEL   = 2'd1;
  localparam logic [FUNC_W-1:0] OP_TEST  = 2'd2;
  localparam logic [FUNC_W-1:0] OP_CLEAR = 2'd3;

  // Command broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;    // latch compare flags against the key
    logic shift_up;  // insert key, move larger entries up one cell
    logic shift_dn;  // remove matched entry, move larger entries down
  } sms_cmd_t;

  // Compare flags a cell hands to the sequencer and to its neighbor
  typedef struct packed {
    logic lt;  // entry valid and below the key
    logic eq;  // entry valid and equal to the key
  } sms_stat_t;

endpackage

>>> sv/sms_cell.sv
// One storage cell of the sorted chain: an entry, its compare flags and
// the shift logic toward its neighbors. Depends on sms_pkg.
module sms_cell
  import sms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] idx,         // position of this cell
  input  logic [CNT_W-1:0] count,       // entries held
  input  logic [KEY_W-1:0] key,
  input  sms_cmd_t         cmd,
  input  logic             prev_lt,     // lower neighbor below key (1 at the bottom)
  input  logic [KEY_W-1:0] prev_entry,
  input  logic [KEY_W-1:0] next_entry,
  output logic [KEY_W-1:0] entry,
  output sms_stat_t        stat
);

  logic [KEY_W-1:0] entry_r;
  logic [KEY_W-1:0] entry_nxt;
  sms_stat_t        stat_r;
  logic             valid;

  assign valid = (idx < count);

  // Compare flags, captured in the compare step before the shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_r <= '0;
    end else if (cmd.cmp_en) begin
      stat_r.lt <= valid && (entry_r < key);
      stat_r.eq <= valid && (entry_r == key);
    end
  end

  // Shift selection: cells at or above the key position move
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.shift_up && !stat_r.lt) begin
      entry_nxt = prev_lt ? key : prev_entry;
    end else if (cmd.shift_dn && !stat_r.lt) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign stat  = stat_r;

endmodule

>>> sv/sorted_membership_set.sv
// Sorted membership set: chain of sms_cell entries plus request sequencer.
// Depends on sms_pkg and sms_cell.
//
// Usage:
//   in_*  : one request per transfer; in_tuser carries the operation
//           (add, delete, test, clear), in_tdata the 32-bit identifier.
//   out_* : one result per request; out_tuser carries ok and full_refused,
//           out_tdata the number of identifiers held after the request.
// Timing: a request is compared in all cells in parallel the cycle after
//   it is taken; the cells shift and the result is registered in the
//   apply step that follows, which waits while an earlier result is
//   still held and not taken. A new request is taken only after the
//   apply step, as the sequencer steps through idle, compare and apply.
// The output register holds a result until taken; the next request is
//   accepted meanwhile and waits in the apply step while out_tready is low.
// Reset (rst_n low, synchronous) empties the set and drops any pending
//   request or result. Entry contents are not cleared; the count gates them.
// Add of a present identifier, or delete/test of an absent one, gives ok 0.
// Add of a new identifier to a full set gives ok 0 and full_refused 1.
module sorted_membership_set
  import sms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] member_id
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [4:0] member_count, [7:5] zero
  output logic [1:0]  out_tuser   // [0] ok, [1] full_refused
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [KEY_W-1:0]  key_r;
  logic [FUNC_W-1:0] func_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r;
  logic              ok_r, ok_nxt;
  logic              full_r, full_nxt;
  logic [MCNT_W-1:0] mcnt_r;

  sms_cmd_t          cmd;
  logic [KEY_W-1:0]  entry_vec [CAPACITY];
  sms_stat_t         stat_vec  [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  logic              hit;
  logic              apply_go;

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             prev_lt;
    logic [KEY_W-1:0] prev_entry;
    logic [KEY_W-1:0] next_entry;

    if (i == 0) begin : g_bottom
      assign prev_lt    = 1'b1;
      assign prev_entry = key_r;
    end else begin : g_mid
      assign prev_lt    = stat_vec[i-1].lt;
      assign prev_entry = entry_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign next_entry = entry_vec[i];
    end else begin : g_below
      assign next_entry = entry_vec[i+1];
    end

    sms_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .idx        (CNT_W'(i)),
      .count      (count_r),
      .key        (key_r),
      .cmd        (cmd),
      .prev_lt    (prev_lt),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .entry      (entry_vec[i]),
      .stat       (stat_vec[i])
    );

    assign eq_vec[i] = stat_vec[i].eq;
  end

  assign hit       = |eq_vec;
  assign in_tready = (state_r == ST_IDLE);
  assign apply_go  = (state_r == ST_APPLY) && (!out_valid_r || out_tready);

  // Sequencer and result decision
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ok_nxt       = 1'b0;
    full_nxt     = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp_en = 1'b1;
        state_nxt  = ST_APPLY;
      end
      ST_APPLY: begin
        if (apply_go) begin
          state_nxt = ST_IDLE;
          case (func_r)
            OP_ADD: begin
              if (hit) begin
                ok_nxt = 1'b0;
              end else if (count_r == CNT_W'(CAPACITY)) begin
                full_nxt = 1'b1;
              end else begin
                cmd.shift_up = 1'b1;
                count_nxt    = count_r + 1'b1;
                ok_nxt       = 1'b1;
              end
            end
            OP_DEL: begin
              if (hit) begin
                cmd.shift_dn = 1'b1;
                count_nxt    = count_r - 1'b1;
                ok_nxt       = 1'b1;
              end
            end
            OP_TEST: begin
              ok_nxt = hit;
            end
            default: begin
              count_nxt = '0;
              ok_nxt    = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (apply_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      key_r  <= in_tdata;
      func_r <= in_tuser;
    end
    if (apply_go) begin
      ok_r   <= ok_nxt;
      full_r <= full_nxt;
      mcnt_r <= MCNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, mcnt_r};
  assign out_tuser  = {full_r, ok_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count exceeds capacity");

  a_rise_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_APPLY))
    else $error("result appeared without an apply step");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_CMP))
    else $error("accepted request did not enter compare");

  a_full_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> !out_tuser[0])
    else $error("full_refused set together with ok");
`endif

endmodule
